/* rtl/pcu_pkg.sv */
`default_nettype none
package pcu_pkg;

  localparam int unsigned MaxVarintBytes = 5;

  typedef enum logic [1:0] {
    KIND_PAL   = 2'd0,
    KIND_STATE = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_PAL   = 2'd0,
    ERR_STATE = 2'd1,
    ERR_VARINT = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    REG_MIN_BITS  = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_GLOBAL    = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] position;
    logic [31:0] value;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

/* rtl/pcu_byte_if.sv */
`default_nettype none
interface pcu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/pcu_result_if.sv */
`default_nettype none
interface pcu_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] position;
  logic [31:0] value;
  logic [1:0]  error_code;
  logic        last;
  modport source (output valid, output kind, output position, output value,
                  output error_code, output last, input ready);
  modport sink (input valid, input kind, input position, input value,
                input error_code, input last, output ready);
endinterface
`default_nettype wire

/* rtl/paletted_container_unpacker_top.sv */
// Paletted container unpacker.
// in_if carries the container stream one byte per beat; out_if carries
// result beats (palette values, state entries, end markers, errors).
// The APB port writes min_entry_bits (0x0), direct_threshold (0x4) and
// global_palette_size (0x8); reads return the stored values.
// A packed word is held until its eighth byte, then a shared shift/compare
// unit extracts one entry per cycle while the output is free; the input
// is not ready during this walk. After a direct width byte, the width is
// found by a search over one bit position per cycle until 2^width reaches
// global_palette_size (width at most 32). Each result sits in an output
// register; while the receiver stalls, the unit halts and the input stays
// not ready.
// Reset returns to awaiting a width byte with registers at 4, 9, 4096.
// An error beat carries last and ends the container; the next byte is
// taken as a new width byte.
`default_nettype none
module paletted_container_unpacker_top import pcu_pkg::*; #(
  parameter int unsigned AddrWidth = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  pcu_byte_if.sink                  in_if,
  pcu_result_if.source              out_if,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [7:0] {
    ST_WIDTH  = 8'b0000_0001,
    ST_DWIDTH = 8'b0000_0010,
    ST_SVAL   = 8'b0000_0100,
    ST_SLEN   = 8'b0000_1000,
    ST_PLEN   = 8'b0001_0000,
    ST_PENT   = 8'b0010_0000,
    ST_COUNT  = 8'b0100_0000,
    ST_WORD   = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  logic        unpack_q, unpack_d;
  logic [4:0]  min_bits_q;
  logic [5:0]  thresh_q;
  logic [30:0] gsize_q;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  vcnt_q, vcnt_d;
  logic [5:0]  width_q, width_d;
  logic [31:0] pal_len_q, pal_len_d;
  logic        pal_use_q, pal_use_d;
  logic [31:0] remain_q, remain_d;
  logic [63:0] word_q, word_d;
  logic [2:0]  wcnt_q, wcnt_d;
  logic [15:0] idx_q, idx_d;
  logic [6:0]  bitpos_q, bitpos_d;
  logic        final_q, final_d;
  logic        ovalid_q, ovalid_d;
  result_t     res_q, res_d;

  logic wr_en, accept, out_free;
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[AddrWidth-1:2] > 2 ? 2'd3 : 2'(paddr[AddrWidth-1:2]);

  always_comb begin
    unique case (reg_idx)
      REG_MIN_BITS:  prdata = {27'd0, min_bits_q};
      REG_THRESHOLD: prdata = {26'd0, thresh_q};
      REG_GLOBAL:    prdata = {1'b0, gsize_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bits_q <= 5'd4;
      thresh_q   <= 6'd9;
      gsize_q    <= 31'd4096;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_BITS:  min_bits_q <= pwdata[4:0];
        REG_THRESHOLD: thresh_q   <= pwdata[5:0];
        REG_GLOBAL:    gsize_q    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  assign out_free = !ovalid_q || out_if.ready;
  assign in_if.ready = !unpack_q && state_q != ST_DWIDTH && out_free;
  assign accept = in_if.valid && in_if.ready;

  // varint step on the incoming byte
  logic [5:0]  vshift;
  logic [6:0]  vbits;
  logic        v_ovf, v_done;
  logic [31:0] v_val;
  logic [38:0] vbits_sh;
  always_comb begin
    vshift = 6'(7 * vcnt_q);
    vbits = in_if.data_byte[6:0];
    vbits_sh = 39'(vbits) << vshift;
    v_ovf = (vshift >= 6'd32) || (vbits_sh[38:32] != '0);
    v_val = acc_q | vbits_sh[31:0];
    v_done = !v_ovf && !in_if.data_byte[7];
    if (!v_ovf && in_if.data_byte[7] && 32'(vcnt_q) + 1 >= MaxVarintBytes) v_ovf = 1'b1;
  end

  // shared entry extractor: shift word to the current bit position and compare
  logic [5:0]  w_eff;
  logic [63:0] mask, shifted;
  logic [31:0] entry;
  logic        entry_bad;
  logic        last_entry;
  always_comb begin
    w_eff = width_q == '0 ? 6'd1 : width_q;
    mask = (64'd1 << w_eff) - 64'd1;
    shifted = word_q >> bitpos_q;
    entry = 32'(shifted & mask);
    entry_bad = (pal_use_q && entry > pal_len_q) || ({1'b0, entry} > {2'b0, gsize_q});
    // no room for another whole entry after this one
    last_entry = ({1'b0, bitpos_q} + {1'b0, w_eff, 1'b0}) > 8'd64;
  end

  logic [15:0] idx_inc;
  assign idx_inc = idx_q == 16'hFFFF ? idx_q : idx_q + 16'd1;

  always_comb begin
    state_d = state_q; unpack_d = unpack_q;
    acc_d = acc_q; vcnt_d = vcnt_q; width_d = width_q;
    pal_len_d = pal_len_q; pal_use_d = pal_use_q; remain_d = remain_q;
    word_d = word_q; wcnt_d = wcnt_q; idx_d = idx_q; bitpos_d = bitpos_q;
    final_d = final_q; res_d = res_q;
    ovalid_d = ovalid_q && !out_if.ready;

    if (state_q == ST_DWIDTH) begin
      // one bit position per cycle until 2^w >= size
      if (width_q < 6'd32 && (33'd1 << width_q) < {2'b0, gsize_q})
        width_d = width_q + 6'd1;
      else begin
        if (width_q == '0) width_d = 6'd1;
        state_d = ST_COUNT;
      end
    end else if (unpack_q) begin
      if (out_free) begin
        ovalid_d = 1'b1;
        if (entry_bad) begin
          res_d = '{KIND_ERR, idx_q, entry, ERR_STATE, 1'b1};
          unpack_d = 1'b0; state_d = ST_WIDTH;
          acc_d = '0; vcnt_d = '0; word_d = '0; wcnt_d = '0; remain_d = '0;
        end else begin
          res_d = '{KIND_STATE, idx_q, entry, ERR_PAL, final_q && last_entry};
          idx_d = idx_inc;
          bitpos_d = bitpos_q + {1'b0, w_eff};
          if (last_entry) begin
            unpack_d = 1'b0;
            if (final_q) begin
              state_d = ST_WIDTH; remain_d = '0;
            end
          end
        end
      end
    end else if (accept) begin
      unique case (state_q)
        ST_WIDTH: begin
          idx_d = '0;
          if (in_if.data_byte == 8'd0) state_d = ST_SVAL;
          else if ({1'b0, in_if.data_byte} >= {3'b0, thresh_q}) begin
            width_d = '0; pal_use_d = 1'b0; pal_len_d = '0; state_d = ST_DWIDTH;
          end else begin
            width_d = in_if.data_byte < {3'b0, min_bits_q} ? {1'b0, min_bits_q}
                                                           : in_if.data_byte[5:0];
            pal_use_d = 1'b1; state_d = ST_PLEN;
          end
        end
        ST_WORD: begin
          word_d = {word_q[55:0], in_if.data_byte};
          wcnt_d = wcnt_q + 3'd1;
          if (wcnt_q == 3'd7) begin
            wcnt_d = '0;
            remain_d = remain_q - 32'd1;
            final_d = remain_q == 32'd1;
            bitpos_d = '0;
            unpack_d = 1'b1;
          end
        end
        default: begin
          acc_d = v_val; vcnt_d = vcnt_q + 3'd1;
          if (v_ovf || v_done) begin acc_d = '0; vcnt_d = '0; end
          if (v_ovf) begin
            ovalid_d = 1'b1;
            res_d = '{KIND_ERR, idx_q, 32'd0, ERR_VARINT, 1'b1};
            state_d = ST_WIDTH; word_d = '0; wcnt_d = '0; remain_d = '0;
          end else if (v_done) begin
            case (state_q)
              ST_SVAL: begin
                ovalid_d = 1'b1;
                res_d = '{KIND_PAL, 16'd0, v_val, ERR_PAL, 1'b0};
                state_d = ST_SLEN;
              end
              ST_SLEN: begin
                ovalid_d = 1'b1;
                res_d = '{KIND_END, 16'd0, 32'd0, ERR_PAL, 1'b1};
                state_d = ST_WIDTH; remain_d = '0;
              end
              ST_PLEN: begin
                pal_len_d = v_val[31] ? '0 : v_val;
                remain_d = v_val[31] ? '0 : v_val;
                idx_d = '0;
                state_d = (v_val[31] || v_val == '0) ? ST_COUNT : ST_PENT;
              end
              ST_PENT: begin
                ovalid_d = 1'b1;
                if ({1'b0, v_val} > {2'b0, gsize_q}) begin
                  res_d = '{KIND_ERR, idx_q, v_val, ERR_PAL, 1'b1};
                  state_d = ST_WIDTH; remain_d = '0; word_d = '0; wcnt_d = '0;
                end else begin
                  res_d = '{KIND_PAL, idx_q, v_val, ERR_PAL, 1'b0};
                  idx_d = idx_inc;
                  remain_d = remain_q - 32'd1;
                  if (remain_q == 32'd1) state_d = ST_COUNT;
                end
              end
              default: begin
                if (v_val[31] || v_val == '0) begin
                  ovalid_d = 1'b1;
                  res_d = '{KIND_END, 16'd0, 32'd0, ERR_PAL, 1'b1};
                  state_d = ST_WIDTH; remain_d = '0;
                end else begin
                  remain_d = v_val; word_d = '0; wcnt_d = '0; idx_d = '0;
                  state_d = ST_WORD;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WIDTH; unpack_q <= 1'b0; ovalid_q <= 1'b0;
      acc_q <= '0; vcnt_q <= '0; width_q <= '0; pal_len_q <= '0;
      pal_use_q <= 1'b0; remain_q <= '0; word_q <= '0; wcnt_q <= '0;
      idx_q <= '0; bitpos_q <= '0; final_q <= 1'b0;
    end else begin
      state_q <= state_d; unpack_q <= unpack_d; ovalid_q <= ovalid_d;
      acc_q <= acc_d; vcnt_q <= vcnt_d; width_q <= width_d; pal_len_q <= pal_len_d;
      pal_use_q <= pal_use_d; remain_q <= remain_d; word_q <= word_d; wcnt_q <= wcnt_d;
      idx_q <= idx_d; bitpos_q <= bitpos_d; final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_if.valid      = ovalid_q;
  assign out_if.kind       = res_q.kind;
  assign out_if.position   = res_q.position;
  assign out_if.value      = res_q.value;
  assign out_if.error_code = res_q.error_code;
  assign out_if.last       = res_q.last;

  a_no_accept_while_unpacking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unpack_q |-> !in_if.ready) else $error("byte taken during unpack");
  a_result_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_if.ready |=> ovalid_q && $stable(res_q))
    else $error("result lost under stall");
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && res_q.kind == KIND_ERR |-> res_q.last) else $error("error without last");

endmodule
`default_nettype wire
